// File: sv/tdpt_pkg.sv
package tdpt_pkg;

   localparam int CAND_WIDTH = 16;

   typedef struct packed {
      logic load_candidate;
      logic start_trial;
      logic start_divide;
      logic divide_step;
      logic next_divisor;
      logic load_result;
      logic result_prime;
   } cmd_type;

   typedef struct packed {
      logic below_two;
      logic square_exceeds;
      logic divide_last;
      logic remainder_zero;
      logic result_free;
   } status_type;

endpackage

// File: sv/tdpt_if.sv
interface tdpt_req_if;
   import tdpt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CAND_WIDTH-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink (input valid, input candidate, output ready);
endinterface

interface tdpt_rsp_if;
   import tdpt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  is_prime;
   logic [CAND_WIDTH-1:0] tested_value;

   modport source (output valid, output is_prime, output tested_value, input ready);
   modport sink (input valid, input is_prime, input tested_value, output ready);
endinterface

// File: sv/tdpt_ctrl.sv
module tdpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tdpt_pkg::status_type status,
   output tdpt_pkg::cmd_type    cmd
);
   import tdpt_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_DIVIDE = 3'd2;
   localparam logic [2:0] S_EVAL   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       verdict_ff;
   logic       verdict_in;
   logic       req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in          = state_ff;
      verdict_in        = verdict_ff;
      cmd               = '0;
      cmd.result_prime  = verdict_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load_candidate = 1'b1;
               cmd.start_trial    = 1'b1;
               state_in           = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.below_two) begin
               verdict_in = 1'b0;
               state_in   = S_FINISH;
            end else if (status.square_exceeds) begin
               verdict_in = 1'b1;
               state_in   = S_FINISH;
            end else begin
               cmd.start_divide = 1'b1;
               state_in         = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.divide_step = 1'b1;
            if (status.divide_last) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (status.remainder_zero) begin
               verdict_in = 1'b0;
               state_in   = S_FINISH;
            end else begin
               cmd.next_divisor = 1'b1;
               state_in         = S_CHECK;
            end
         end
         S_FINISH: begin
            if (status.result_free) begin
               cmd.load_result = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         verdict_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         verdict_ff <= verdict_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_CHECK)
      else $error("Accepted transaction did not start a check.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && status.remainder_zero) |=> (state_ff == S_FINISH && !verdict_ff))
      else $error("Exact divisor did not give a composite verdict.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && status.below_two) |=> !verdict_ff)
      else $error("Value below two reported as prime.");

endmodule

// File: sv/tdpt_datapath.sv
module tdpt_datapath #(
   parameter int WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tdpt_pkg::cmd_type                   cmd,
   output tdpt_pkg::status_type                status,
   input  logic [tdpt_pkg::CAND_WIDTH-1:0]     req_candidate,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_is_prime,
   output logic [tdpt_pkg::CAND_WIDTH-1:0]     rsp_tested_value
);
   import tdpt_pkg::*;

   localparam int CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;

   logic [WIDTH+CAND_WIDTH-1:0] cand_ext;
   logic [WIDTH+CAND_WIDTH-1:0] value_ext;
   logic [WIDTH-1:0]            n_ff;
   logic [WIDTH-1:0]            n_in;
   logic [WIDTH-1:0]            d_ff;
   logic [WIDTH-1:0]            d_in;
   logic [WIDTH:0]              sq_ff;
   logic [WIDTH:0]              sq_in;
   logic [WIDTH:0]              rem_ff;
   logic [WIDTH:0]              rem_in;
   logic [WIDTH:0]              shifted;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_prime_ff;
   logic [CAND_WIDTH-1:0]       rsp_value_ff;

   assign cand_ext  = {{WIDTH{1'b0}}, req_candidate};
   assign value_ext = {{CAND_WIDTH{1'b0}}, n_ff};
   assign shifted   = {rem_ff[WIDTH-1:0], n_ff[count_ff]};

   always_comb begin
      n_in     = cmd.load_candidate ? cand_ext[WIDTH-1:0] : n_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      if (cmd.start_trial) begin
         d_in  = WIDTH'(2);
         sq_in = (WIDTH+1)'(4);
      end else if (cmd.next_divisor) begin
         d_in  = d_ff + WIDTH'(1);
         sq_in = sq_ff + {d_ff, 1'b1};
      end
      if (cmd.start_divide) begin
         rem_in   = '0;
         count_in = CNT_W'(WIDTH - 1);
      end else if (cmd.divide_step) begin
         rem_in   = (shifted >= {1'b0, d_ff}) ? shifted - {1'b0, d_ff} : shifted;
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign status.below_two      = (n_ff[WIDTH-1:1] == '0);
   assign status.square_exceeds = (sq_ff > {1'b0, n_ff});
   assign status.divide_last    = (count_ff == '0);
   assign status.remainder_zero = (rem_ff == '0);
   assign status.result_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         d_ff         <= '0;
         sq_ff        <= '0;
         rem_ff       <= '0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         d_ff         <= d_in;
         sq_ff        <= sq_in;
         rem_ff       <= rem_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_prime_ff <= cmd.result_prime;
         rsp_value_ff <= value_ext[CAND_WIDTH-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_prime     = rsp_prime_ff;
   assign rsp_tested_value = rsp_value_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> status.result_free)
      else $error("Result loaded over an undelivered transaction.");

   assert property (@(posedge clock) disable iff (reset)
      cmd.next_divisor |-> !status.remainder_zero && !status.square_exceeds)
      else $error("Divisor advanced past a decided test.");

   assert property (@(posedge clock) disable iff (reset)
      cmd.divide_step |=> rem_ff < {1'b0, d_ff})
      else $error("Partial remainder not below the divisor.");

endmodule

// File: sv/trial_division_prime_test_top.sv
// Channel       Direction  Payload                       Transaction when
// req_channel   in         candidate[15:0]               valid && ready
// rsp_channel   out        is_prime, tested_value[15:0]  valid && ready
//
// Each trial division runs the bit-serial remainder unit over all WIDTH bits of the
// candidate, one quotient bit per cycle, and then evaluates the remainder. The result
// becomes valid as the block returns to idle, where it can take the next candidate.
// Reset is synchronous and active high; no clearing pass is needed.
// A finished result waits in the output register; a new candidate is taken while it waits.
// A stalled result holds the next verdict back until the output register is free.
module trial_division_prime_test_top #(
   parameter int WIDTH = 16
) (
   input logic        clock,
   input logic        reset,
   tdpt_req_if.sink   req_channel,
   tdpt_rsp_if.source rsp_channel
);
   import tdpt_pkg::*;

   cmd_type    cmd;
   status_type status;

   tdpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tdpt_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_candidate    (req_channel.candidate),
      .rsp_valid        (rsp_channel.valid),
      .rsp_ready        (rsp_channel.ready),
      .rsp_is_prime     (rsp_channel.is_prime),
      .rsp_tested_value (rsp_channel.tested_value)
   );

endmodule
